@@ design/coupled_bistable_network_euler_step_assert.svh @@
// Assertion macros shared by the coupled bistable network block.
`ifndef COUPLED_BISTABLE_NETWORK_EULER_STEP_ASSERT_SVH
`define COUPLED_BISTABLE_NETWORK_EULER_STEP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define CBN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("coupled bistable network check failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define CBN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("coupled bistable network check failed");

`endif

@@ design/cbn_pkg.sv @@
// Package with constants and types of the bistable network block.
`default_nettype none
package cbn_pkg;
	localparam int NODES      = 256;
	localparam int MAX_DEGREE = 16;
	localparam int FRAC_BITS  = 12;

	localparam int NODE_AW = $clog2(NODES);
	localparam int SLOT_W  = $clog2(MAX_DEGREE);
	localparam int NBR_AW  = NODE_AW + SLOT_W;
	localparam int DEG_W   = 5;
	localparam int CNT_W   = NODE_AW + 1;
	localparam int VAL_W   = 16;
	localparam int SUM_W   = 21;
	localparam int SHORT_W = 20;
	localparam int S1_W    = 24;
	localparam int S2_W    = 40;
	localparam int D_W     = 28;
	localparam int DIV_W   = 48;
	localparam int DVS_W   = $clog2(NODES * NODES + 1);
	localparam int SQ_W    = 48;
	localparam int CFG_IW  = 3;

	localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] ONE      = 64'sd1 <<< FRAC_BITS;

	localparam logic [2:0] REQ_WR_NODE = 3'd0;
	localparam logic [2:0] REQ_WR_NBR  = 3'd1;
	localparam logic [2:0] REQ_STEP    = 3'd2;
	localparam logic [2:0] REQ_RD_NODE = 3'd3;
	localparam logic [2:0] REQ_STATS   = 3'd4;

	localparam logic [CFG_IW-1:0] CFG_STEP_SIZE = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_BIAS      = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_COUPLING  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_ACTIVE    = 3'd3;

	typedef struct packed {
		logic [2:0]              req_type;
		logic [7:0]              node_index;
		logic [3:0]              slot;
		logic [7:0]              neighbor_index;
		logic signed [VAL_W-1:0] value;
		logic                    bias_flag;
		logic [DEG_W-1:0]        degree;
	} in_item_t;

	typedef struct packed {
		logic [2:0]              echo_type;
		logic signed [VAL_W-1:0] read_value;
		logic signed [VAL_W-1:0] mean_value;
		logic [14:0]             spread_value;
	} out_item_t;

	typedef struct packed {
		logic [14:0]             step_size;
		logic signed [VAL_W-1:0] bias;
		logic signed [VAL_W-1:0] coupling;
		logic [CNT_W-1:0]        active_nodes;
	} cfg_t;

	typedef struct packed {
		logic                    mark;
		logic [DEG_W-1:0]        degree;
		logic signed [VAL_W-1:0] value;
	} node_word_t;

	typedef struct packed {
		logic               we;
		logic [NODE_AW-1:0] waddr;
		logic [NODE_AW-1:0] raddr;
		node_word_t         wdata;
	} node_mem_t;

	typedef struct packed {
		logic               we;
		logic [NODE_AW-1:0] waddr;
		logic [NODE_AW-1:0] raddr;
		logic [VAL_W-1:0]   wdata;
	} drv_mem_t;

	typedef struct packed {
		logic              we;
		logic [NBR_AW-1:0] waddr;
		logic [NBR_AW-1:0] raddr;
		logic [7:0]        wdata;
	} nbr_mem_t;

	typedef enum logic [4:0] {
		S_IDLE, S_RD_WAIT, S_FIN,
		S_ST_RD, S_ST_X, S_ST_ACC, S_ST_M1, S_ST_M2, S_ST_M3, S_ST_M4,
		S_ST_MW, S_ST_VD, S_ST_VW, S_ST_SW,
		S_P_RD, S_P_X, S_P_C1, S_P_C2, S_P_NA, S_P_NB, S_P_NC,
		S_P_DIV, S_P_DW, S_P_CM, S_P_WD,
		S_U_RD, S_U_X, S_U_W
	} core_state_t;
endpackage
`default_nettype wire

@@ design/cbn_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module cbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/cbn_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module cbn_div import cbn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             short_op,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic      [DIV_W-1:0] quotient
);
	localparam int CW = $clog2(DIV_W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DVS_W:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0] trial;

	assign trial    = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= short_op ? CW'(SHORT_W) : CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= short_op ? (dividend << (DIV_W - SHORT_W)) : dividend;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

@@ design/cbn_sqrt.sv @@
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module cbn_sqrt import cbn_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SQ_W-1:0]     radicand,
	output logic                     done,
	output logic      [SQ_W/2-1:0]   root
);
	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;

	assign trial = r_q + bit_q;
	assign done  = done_q;
	assign root  = r_q[SQ_W/2-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == SQ_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule
`default_nettype wire

@@ design/cbn_core.sv @@
// Sequencer and shared datapath; walks the node memories for step and stats.
`default_nettype none
module cbn_core import cbn_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cfg_t                    cfg,
	input  wire in_item_t                req,
	input  wire logic                    req_fire,
	output logic                         busy,
	output logic                         res_valid,
	output out_item_t                    res,
	input  wire logic                    res_ack,
	output node_mem_t                    node_mem,
	input  wire node_word_t              node_rdata,
	output drv_mem_t                     drv_mem,
	input  wire logic signed [VAL_W-1:0] drv_rdata,
	output nbr_mem_t                     nbr_mem,
	input  wire logic [7:0]              nbr_rdata
);
	function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
		rnd = (v + HALF_LSB) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			sat16 = 16'sh7fff;
		end else if (v < -64'sd32768) begin
			sat16 = -16'sh8000;
		end else begin
			sat16 = v[VAL_W-1:0];
		end
	endfunction

	core_state_t state_q, state_d;
	logic [NODES-1:0] nvalid_q;
	logic             rvalid_s1;

	out_item_t               res_q;
	logic [CNT_W-1:0]        idx_q;
	logic [DEG_W-1:0]        j_q;
	logic signed [VAL_W-1:0] x_q;
	logic                    mark_q;
	logic [DEG_W-1:0]        deg_q;
	logic signed [D_W-1:0]   d_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    kin_q;
	logic signed [S1_W-1:0]  s1_q;
	logic signed [S2_W-1:0]  s2_q;
	logic [DIV_W-1:0]        t1_q;
	logic [DIV_W-1:0]        dd_q;
	logic [DVS_W-1:0]        nn_q;
	node_word_t              w_q;

	logic signed [39:0] mul_a;
	logic signed [23:0] mul_b;
	logic signed [63:0] mul_s1;
	logic signed [63:0] mul_rnd;

	logic                    div_start, div_short, div_done;
	logic [DIV_W-1:0]        div_dividend, div_quo;
	logic [DVS_W-1:0]        div_divisor;
	logic                    sq_start, sq_done;
	logic [SQ_W/2-1:0]       sq_root;

	node_word_t              nrd;
	logic [CNT_W-1:0]        n_c;
	logic                    last_node;
	logic [DEG_W-1:0]        deg_sat;
	logic [SHORT_W-1:0]      sum_abs;
	logic [S1_W-1:0]         s1_abs;
	logic signed [SUM_W-1:0] nb_mean;
	logic signed [DIV_W-1:0] var_diff;
	logic signed [VAL_W-1:0] upd_value;

	assign nrd     = rvalid_s1 ? node_rdata : '0;
	assign mul_rnd = rnd(mul_s1);
	assign sum_abs = sum_q[SUM_W-1] ? SHORT_W'(-sum_q) : SHORT_W'(sum_q);
	assign s1_abs  = s1_q[S1_W-1] ? S1_W'(-s1_q) : S1_W'(s1_q);
	assign nb_mean = sum_q[SUM_W-1] ? -$signed({1'b0, div_quo[SHORT_W-1:0]})
	                                :  $signed({1'b0, div_quo[SHORT_W-1:0]});
	assign var_diff  = $signed(t1_q) - $signed(mul_s1[DIV_W-1:0]);
	assign upd_value = sat16(64'(w_q.value) + mul_rnd);
	assign deg_sat   = (req.degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : req.degree;
	assign last_node = (idx_q == n_c - CNT_W'(1));

	always_comb begin
		if (cfg.active_nodes == '0) begin
			n_c = CNT_W'(1);
		end else if (cfg.active_nodes > CNT_W'(NODES)) begin
			n_c = CNT_W'(NODES);
		end else begin
			n_c = cfg.active_nodes;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res       = res_q;

	cbn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.short_op (div_short),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	cbn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (div_quo),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			nvalid_q <= '0;
		end else begin
			state_q <= state_d;
			if (node_mem.we) begin
				nvalid_q[node_mem.waddr] <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		node_mem     = '0;
		drv_mem      = '0;
		nbr_mem      = '0;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_short    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		sq_start     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					unique case (req.req_type)
						REQ_WR_NODE: begin
							if (int'(req.node_index) < NODES) begin
								node_mem.we    = 1'b1;
								node_mem.waddr = req.node_index[NODE_AW-1:0];
								node_mem.wdata = '{mark: req.bias_flag, degree: deg_sat,
								                   value: req.value};
							end
							state_d = S_FIN;
						end
						REQ_WR_NBR: begin
							if (int'(req.node_index) < NODES && int'(req.slot) < MAX_DEGREE) begin
								nbr_mem.we    = 1'b1;
								nbr_mem.waddr = {req.node_index[NODE_AW-1:0],
								                 req.slot[SLOT_W-1:0]};
								nbr_mem.wdata = req.neighbor_index;
							end
							state_d = S_FIN;
						end
						REQ_RD_NODE: begin
							node_mem.raddr = req.node_index[NODE_AW-1:0];
							state_d        = S_RD_WAIT;
						end
						REQ_STATS: state_d = S_ST_RD;
						REQ_STEP:  state_d = S_P_RD;
						default:   state_d = S_FIN;
					endcase
				end
			end
			S_RD_WAIT: state_d = S_FIN;
			S_FIN: begin
				if (res_ack) begin
					state_d = S_IDLE;
				end
			end
			S_ST_RD: begin
				node_mem.raddr = idx_q[NODE_AW-1:0];
				state_d        = S_ST_X;
			end
			S_ST_X: begin
				mul_a   = 40'(nrd.value);
				mul_b   = 24'(nrd.value);
				state_d = S_ST_ACC;
			end
			S_ST_ACC: state_d = last_node ? S_ST_M1 : S_ST_RD;
			S_ST_M1: begin
				mul_a   = 40'(s2_q);
				mul_b   = 24'(n_c);
				state_d = S_ST_M2;
			end
			S_ST_M2: begin
				mul_a   = 40'(s1_q);
				mul_b   = s1_q;
				state_d = S_ST_M3;
			end
			S_ST_M3: begin
				mul_a   = 40'(n_c);
				mul_b   = 24'(n_c);
				state_d = S_ST_M4;
			end
			S_ST_M4: begin
				div_start    = 1'b1;
				div_dividend = DIV_W'(s1_abs);
				div_divisor  = DVS_W'(n_c);
				state_d      = S_ST_MW;
			end
			S_ST_MW: begin
				if (div_done) begin
					state_d = S_ST_VD;
				end
			end
			S_ST_VD: begin
				div_start    = 1'b1;
				div_dividend = dd_q;
				div_divisor  = nn_q;
				state_d      = S_ST_VW;
			end
			S_ST_VW: begin
				if (div_done) begin
					sq_start = 1'b1;
					state_d  = S_ST_SW;
				end
			end
			S_ST_SW: begin
				if (sq_done) begin
					state_d = S_FIN;
				end
			end
			S_P_RD: begin
				node_mem.raddr = idx_q[NODE_AW-1:0];
				state_d        = S_P_X;
			end
			S_P_X: begin
				mul_a   = 40'(nrd.value);
				mul_b   = 24'(nrd.value);
				state_d = S_P_C1;
			end
			S_P_C1: begin
				mul_a   = mul_rnd[39:0];
				mul_b   = 24'(x_q);
				state_d = S_P_C2;
			end
			S_P_C2: state_d = (deg_q == '0) ? S_P_WD : S_P_NA;
			S_P_NA: begin
				nbr_mem.raddr = {idx_q[NODE_AW-1:0], j_q[SLOT_W-1:0]};
				state_d       = S_P_NB;
			end
			S_P_NB: begin
				node_mem.raddr = nbr_rdata[NODE_AW-1:0];
				state_d        = S_P_NC;
			end
			S_P_NC: state_d = (j_q + DEG_W'(1) == deg_q) ? S_P_DIV : S_P_NA;
			S_P_DIV: begin
				div_start    = 1'b1;
				div_short    = 1'b1;
				div_dividend = DIV_W'(sum_abs);
				div_divisor  = DVS_W'(deg_q);
				state_d      = S_P_DW;
			end
			S_P_DW: begin
				if (div_done) begin
					mul_a   = 40'(nb_mean) - 40'(x_q);
					mul_b   = 24'(cfg.coupling);
					state_d = S_P_CM;
				end
			end
			S_P_CM: state_d = S_P_WD;
			S_P_WD: begin
				drv_mem.we    = 1'b1;
				drv_mem.waddr = idx_q[NODE_AW-1:0];
				drv_mem.wdata = sat16(64'(d_q));
				state_d       = last_node ? S_U_RD : S_P_RD;
			end
			S_U_RD: begin
				node_mem.raddr = idx_q[NODE_AW-1:0];
				drv_mem.raddr  = idx_q[NODE_AW-1:0];
				state_d        = S_U_X;
			end
			S_U_X: begin
				mul_a   = 40'(drv_rdata);
				mul_b   = 24'(cfg.step_size);
				state_d = S_U_W;
			end
			S_U_W: begin
				node_mem.we    = 1'b1;
				node_mem.waddr = idx_q[NODE_AW-1:0];
				node_mem.wdata = '{mark: w_q.mark, degree: w_q.degree, value: upd_value};
				state_d        = last_node ? S_FIN : S_U_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_s1    <= mul_a * mul_b;
		rvalid_s1 <= nvalid_q[node_mem.raddr];
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					res_q <= '{echo_type: req.req_type, read_value: '0,
					           mean_value: '0, spread_value: '0};
					idx_q <= '0;
					s1_q  <= '0;
					s2_q  <= '0;
				end
			end
			S_RD_WAIT: res_q.read_value <= nrd.value;
			S_ST_X:    s1_q <= s1_q + S1_W'(nrd.value);
			S_ST_ACC: begin
				s2_q  <= s2_q + mul_s1[S2_W-1:0];
				idx_q <= idx_q + CNT_W'(1);
			end
			S_ST_M2: t1_q <= mul_s1[DIV_W-1:0];
			S_ST_M3: dd_q <= var_diff[DIV_W-1] ? DIV_W'(-var_diff) : DIV_W'(var_diff);
			S_ST_M4: nn_q <= mul_s1[DVS_W-1:0];
			S_ST_MW: begin
				if (div_done) begin
					res_q.mean_value <= s1_q[S1_W-1] ? -div_quo[VAL_W-1:0]
					                                 :  div_quo[VAL_W-1:0];
				end
			end
			S_ST_SW: begin
				if (sq_done) begin
					res_q.spread_value <= (sq_root > (SQ_W/2)'(32767)) ? 15'h7fff
					                                                   : sq_root[14:0];
				end
			end
			S_P_X: begin
				x_q    <= nrd.value;
				mark_q <= nrd.mark;
				deg_q  <= nrd.degree;
				sum_q  <= '0;
				j_q    <= '0;
			end
			S_P_C2: begin
				d_q <= D_W'(64'(x_q) - mul_rnd + 64'(cfg.bias) + (mark_q ? ONE : 64'sd0));
			end
			S_P_NB: kin_q <= (int'(nbr_rdata) < NODES);
			S_P_NC: begin
				sum_q <= sum_q + (kin_q ? SUM_W'(nrd.value) : SUM_W'(0));
				j_q   <= j_q + DEG_W'(1);
			end
			S_P_CM: d_q <= D_W'(64'(d_q) + mul_rnd);
			S_P_WD: idx_q <= last_node ? '0 : idx_q + CNT_W'(1);
			S_U_X:  w_q <= nrd;
			S_U_W:  idx_q <= idx_q + CNT_W'(1);
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ design/coupled_bistable_network_euler_step.sv @@
// Top level of the coupled bistable network block: registers, memories, core, result register.
//
// Usage. Requests arrive on req with req_valid and req_stall; an item is taken at a clock edge
// where req_valid is high and req_stall is low. Each request gives exactly one result item on
// rsp, held with rsp_valid until a clock edge with rsp_stall low. Configuration writes use
// cfg_valid, cfg_ready (always high), cfg_index and cfg_data, and are meant for idle periods.
// The step request is bounded by the single node memory read port, which serves each neighbour
// fetch, and by a 20-step divide for each neighbour mean; statistics use two 48-step divides
// and a 24-step square root. One request is in work at a time; the next one can be taken in
// the cycle after its result has moved into the result register, even while that result is
// stalled. A stalled result holds the core, and so the input, until it moves.
// At reset all node states, bias marks and degrees read as zero (per-entry valid bits), the
// registers take their reset values, and no result is pending.
`default_nettype none
module coupled_bistable_network_euler_step import cbn_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire in_item_t          req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output out_item_t              rsp,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [15:0]       cfg_data
);
	// Configuration registers, reset to step size 410, zero bias and coupling, and 20 active nodes.
	cfg_t cfg_q;

	// Result register between the core and the receiver.
	logic      rsp_valid_q;
	out_item_t rsp_q;

	logic       core_busy;
	logic       res_valid;
	out_item_t  res;
	logic       rsp_free;
	node_mem_t  node_mem;
	node_word_t node_rdata;
	drv_mem_t   drv_mem;
	logic [VAL_W-1:0] drv_rdata;
	nbr_mem_t   nbr_mem;
	logic [7:0] nbr_rdata;

	assign cfg_ready = 1'b1;
	assign req_stall = core_busy;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{step_size: 15'd410, bias: '0, coupling: '0, active_nodes: 9'd20};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STEP_SIZE: cfg_q.step_size    <= cfg_data[14:0];
				CFG_BIAS:      cfg_q.bias         <= cfg_data;
				CFG_COUPLING:  cfg_q.coupling     <= cfg_data;
				CFG_ACTIVE:    cfg_q.active_nodes <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// The result register loads whenever it is empty or being emptied this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_free && res_valid) begin
			rsp_q <= res;
		end
	end

	// Node state, bias mark and degree share one word so a single read returns all three.
	cbn_ram #(.WIDTH($bits(node_word_t)), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_mem.we),
		.waddr (node_mem.waddr),
		.wdata (node_mem.wdata),
		.raddr (node_mem.raddr),
		.rdata (node_rdata)
	);

	// Derivatives of the current step, all formed before any state is updated.
	cbn_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_drv_ram (
		.clk   (clk),
		.we    (drv_mem.we),
		.waddr (drv_mem.waddr),
		.wdata (drv_mem.wdata),
		.raddr (drv_mem.raddr),
		.rdata (drv_rdata)
	);

	// Neighbour lists, addressed by node and slot.
	cbn_ram #(.WIDTH(8), .DEPTH(NODES * MAX_DEGREE)) u_nbr_ram (
		.clk   (clk),
		.we    (nbr_mem.we),
		.waddr (nbr_mem.waddr),
		.wdata (nbr_mem.wdata),
		.raddr (nbr_mem.raddr),
		.rdata (nbr_rdata)
	);

	cbn_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req        (req),
		.req_fire   (req_valid && !req_stall),
		.busy       (core_busy),
		.res_valid  (res_valid),
		.res        (res),
		.res_ack    (rsp_free),
		.node_mem   (node_mem),
		.node_rdata (node_rdata),
		.drv_mem    (drv_mem),
		.drv_rdata  ($signed(drv_rdata)),
		.nbr_mem    (nbr_mem),
		.nbr_rdata  (nbr_rdata)
	);

	// Every accepted item keeps the core busy for at least the following cycle.
	`include "coupled_bistable_network_euler_step_assert.svh"
	`CBN_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, req_stall)
	// A new result only appears after the core has been working on a request.
	`CBN_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(req_stall))
	// The core never hands over a result while the result register is full and stalled.
	`CBN_ASSERT_NEXT(a_no_overwrite, rsp_valid && rsp_stall, $stable(rsp))
endmodule
`default_nettype wire
